// ----- rtl/core/crcv_pkg.sv -----
// ----------------------------------------------------------------------------
// crcv_pkg: shared types and constants of the CRC-checked record validator
// Item structs for both channels, the record-stage control struct, status
// codes and the record format constants.
// ----------------------------------------------------------------------------
package crcv_pkg;

	// Fixed record layout.
	localparam int unsigned MAGIC_BYTES = 8;
	localparam int unsigned HDR_TRL_BYTES = 24;

	// Record magic, first byte in the most significant lane.
	localparam logic [63:0] REC_MAGIC = 64'h4441_574D_4958_3031;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int unsigned MAX_PL_W = 25;
	localparam logic [MAX_PL_W-1:0] MAX_PL_RESET = 25'h010_0000;

	// Status codes, in priority order of the checks.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_BAD_LEN = 3'd3;
	localparam logic [2:0] ST_BAD_CRC = 3'd4;
	localparam logic [2:0] ST_ZERO_REV = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_record;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] revision;
		logic [31:0] payload_length;
	} out_item_t;

	// Control handed from the top level to the record stage.
	typedef struct packed {
		logic       go;
		logic       last;
		logic [7:0] data_byte;
	} rec_step_t;

endpackage

// ----- rtl/core/crcv_crc_byte.sv -----
// ----------------------------------------------------------------------------
// crcv_crc_byte: one-byte update of the reflected CRC-32
// Eight unrolled shift and conditional xor steps on the running remainder.
// ----------------------------------------------------------------------------
module crcv_crc_byte
	import crcv_pkg::*;
(
	input  logic [31:0] crc_cur,
	input  logic [7:0]  data_in,
	output logic [31:0] crc_nxt
);

	always_comb begin
		logic [31:0] c;
		c = crc_cur ^ {24'd0, data_in};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		crc_nxt = c;
	end

endmodule

// ----- rtl/core/crcv_record.sv -----
// ----------------------------------------------------------------------------
// crcv_record: per-record state and final verdict
// Tracks byte count, magic match, header fields, the CRC and the four-byte
// trailer window, and forms the result item for the final byte.
// ----------------------------------------------------------------------------
module crcv_record
	import crcv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  rec_step_t           step,
	input  logic [MAX_PL_W-1:0] max_payload,
	output out_item_t           verdict
);

	logic [31:0] cnt_q, cnt_d;
	logic        magic_q, magic_d;
	logic [63:0] rev_q, rev_d;
	logic [31:0] len_q, len_d;
	logic [31:0] crc_q, crc_d, crc_upd;
	logic [31:0] win_q, win_d;

	logic [25:0] limit;
	logic [31:0] trailer;
	logic        in_magic, in_rev, in_len;

	crcv_crc_byte u_crc (
		.crc_cur(crc_q),
		.data_in(win_q[31:24]),
		.crc_nxt(crc_upd)
	);

	assign in_magic = (cnt_q[31:3] == 29'd0);
	assign in_rev = (cnt_q[31:3] == 29'd1);
	assign in_len = (cnt_q[31:2] == 30'd4);

	always_comb begin
		magic_d = magic_q;
		if (in_magic && (step.data_byte != REC_MAGIC[{~cnt_q[2:0], 3'b000} +: 8])) begin
			magic_d = 1'b0;
		end

		rev_d = rev_q;
		for (int k = 0; k < 8; k++) begin
			if (in_rev && (cnt_q[2:0] == 3'(k))) begin
				rev_d[8*k +: 8] = rev_q[8*k +: 8] | step.data_byte;
			end
		end

		len_d = len_q;
		for (int k = 0; k < 4; k++) begin
			if (in_len && (cnt_q[1:0] == 2'(k))) begin
				len_d[8*k +: 8] = len_q[8*k +: 8] | step.data_byte;
			end
		end

		// Bytes reach the CRC only after leaving the trailer window.
		crc_d = (cnt_q[31:2] != 30'd0) ? crc_upd : crc_q;
		win_d = {win_q[23:0], step.data_byte};
		cnt_d = (&cnt_q) ? cnt_q : cnt_q + 32'd1;
	end

	always_comb begin
		limit = {1'b0, max_payload} + 26'(HDR_TRL_BYTES);
		trailer = {win_d[7:0], win_d[15:8], win_d[23:16], win_d[31:24]};

		verdict.revision = rev_d;
		verdict.payload_length = len_d;
		if (cnt_d > {6'd0, limit}) begin
			verdict.status = ST_TOO_LARGE;
		end else if ((cnt_d < 32'(HDR_TRL_BYTES)) || !magic_d) begin
			verdict.status = ST_BAD_MAGIC;
		end else if (len_d != cnt_d - 32'(HDR_TRL_BYTES)) begin
			verdict.status = ST_BAD_LEN;
		end else if (trailer != (crc_d ^ CRC_INIT)) begin
			verdict.status = ST_BAD_CRC;
		end else if (rev_d == 64'd0) begin
			verdict.status = ST_ZERO_REV;
		end else begin
			verdict.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 32'd0;
			magic_q <= 1'b1;
			rev_q <= 64'd0;
			len_q <= 32'd0;
			crc_q <= CRC_INIT;
			win_q <= 32'd0;
		end else if (step.go) begin
			if (step.last) begin
				cnt_q <= 32'd0;
				magic_q <= 1'b1;
				rev_q <= 64'd0;
				len_q <= 32'd0;
				crc_q <= CRC_INIT;
				win_q <= 32'd0;
			end else begin
				cnt_q <= cnt_d;
				magic_q <= magic_d;
				rev_q <= rev_d;
				len_q <= len_d;
				crc_q <= crc_d;
				win_q <= win_d;
			end
		end
	end

endmodule

// ----- rtl/core/crc_checked_record_validator.sv -----
// ----------------------------------------------------------------------------
// crc_checked_record_validator: streaming check of CRC-framed records
// Input register, record stage, result register; one byte per unstalled cycle.
// ----------------------------------------------------------------------------
// The block takes one record byte per item and flags the final byte with
// end_of_record. It sustains one item per clock cycle unless stalled: each byte
// is captured in an input register, from which the record stage folds it into
// the byte count, header fields, trailer window and CRC. Only the final byte of
// a record yields a result item, which the record stage forms and which is
// loaded into the output register as that byte moves on. The output register
// lets the block keep taking bytes while a result waits to be taken; a stall
// on the output side only backs up into the input once a second final byte
// needs the output register. The result reports the first failing check in
// the order: record too large, bad magic or truncated, bad length field, CRC
// mismatch, zero revision. The payload limit register is written through
// cfg_we and cfg_wdata and should only be changed while no record is in flight.
module crc_checked_record_validator
	import crcv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [MAX_PL_W-1:0] cfg_wdata
);

	logic                in_valid_s1;
	in_item_t            in_item_s1;
	logic                advance;
	logic                out_valid_q;
	out_item_t           out_item_q;
	logic [MAX_PL_W-1:0] max_payload_q;
	rec_step_t           step;
	out_item_t           verdict;

	// A byte in the input register moves on unless it closes a record while the
	// output register holds an earlier result that is not being taken.
	assign advance = in_valid_s1 && (!in_item_s1.end_of_record || !out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	assign step.go = advance;
	assign step.last = in_item_s1.end_of_record;
	assign step.data_byte = in_item_s1.data_byte;

	crcv_record u_record (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.max_payload(max_payload_q),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PL_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_item_s1.end_of_record) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_item_s1.end_of_record) begin
			out_item_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// ----- rtl/core/crcv_checker.sv -----
// ----------------------------------------------------------------------------
// crcv_checker: port-level assertions for the record validator
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module crcv_checker
	import crcv_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input in_item_t            in_item,
	input logic                out_valid,
	input logic                out_ready,
	input out_item_t           out_item
);

	// An offered byte stays offered, unchanged, until the block takes it.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input item changed or dropped while stalled");

	// A result waiting to be taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed or dropped while stalled");

	// Status is always one of the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.status == ST_OK) || (out_item.status == ST_TOO_LARGE) ||
			(out_item.status == ST_BAD_MAGIC) || (out_item.status == ST_BAD_LEN) ||
			(out_item.status == ST_BAD_CRC) || (out_item.status == ST_ZERO_REV))
		else $error("undefined status code");

	// A passing record never carries a zero revision.
	a_ok_rev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_OK) |-> (out_item.revision != 64'd0))
		else $error("ok status with zero revision");

	// With the output register empty nothing blocks the input side.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

endmodule

bind crc_checked_record_validator crcv_checker u_crcv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_item(in_item),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

// ----- verif/tb_crc_checked_record_validator.sv -----
// ----------------------------------------------------------------------------
// tb_crc_checked_record_validator: self-checking bench for the record validator
// Builds CRC-framed records byte by byte, predicts the verdict of every record
// from a model kept in step with the accepted items, and compares each result
// item field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_crc_checked_record_validator;
	import crcv_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int DRAIN_CYCLES = RESULT_LATENCY + 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int PRESSURE_HOLD = 400;
	localparam logic [MAX_PL_W-1:0] PL_LIMIT_TOP = 25'h100_0000;

	// Shapes of record the generator can build.
	typedef enum int {
		REC_GOOD,
		REC_BAD_MAGIC,
		REC_BAD_LEN,
		REC_BAD_CRC,
		REC_JUNK
	} rec_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [MAX_PL_W-1:0] cfg_wdata = '0;

	// Bytes waiting to be offered, and verdicts waiting to come out.
	in_item_t pending_bytes[$];
	out_item_t expected_verdicts[$];

	// Idle rates in percent for each side, and the length of a forced
	// receiver hold-off, which the receiver process counts down itself.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_len = 0;

	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	out_item_t want;

	// Predictor state: the payload limit and the record being gathered.
	logic [MAX_PL_W-1:0] payload_limit;
	logic [31:0] rec_bytes;
	logic magic_seen_ok;
	logic [63:0] rev_gather;
	logic [31:0] len_gather;
	logic [31:0] crc_run;
	logic [31:0] tail_bytes;

	crc_checked_record_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// One byte of the reflected CRC-32, bit-serial.
	function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
		int k;
		c ^= {24'd0, b};
		for (k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void clear_record_state();
		rec_bytes = '0;
		magic_seen_ok = 1'b1;
		rev_gather = '0;
		len_gather = '0;
		crc_run = CRC_INIT;
		tail_bytes = '0;
	endfunction

	// Folds one accepted byte into the record state. On the final byte the
	// verdict is worked out in check order and queued as the expected result.
	function automatic void track_record_byte(in_item_t it);
		logic [31:0] idx;
		logic [31:0] trailer;
		logic [31:0] size_limit;
		out_item_t verdict;
		idx = rec_bytes;
		if (idx < MAGIC_BYTES) begin
			if (it.data_byte != REC_MAGIC[63 - 8 * int'(idx) -: 8]) begin
				magic_seen_ok = 1'b0;
			end
		end else if (idx < 16) begin
			rev_gather |= 64'(it.data_byte) << (8 * (idx - 8));
		end else if (idx < 20) begin
			len_gather |= 32'(it.data_byte) << (8 * (idx - 16));
		end
		// The CRC only sees a byte once it has left the four-byte window,
		// so the trailer itself never enters it.
		if (idx >= 4) begin
			crc_run = crc32_step(crc_run, tail_bytes[31:24]);
		end
		tail_bytes = {tail_bytes[23:0], it.data_byte};
		if (rec_bytes != '1) begin
			rec_bytes++;
		end
		if (!it.end_of_record) begin
			return;
		end
		size_limit = 32'(payload_limit) + HDR_TRL_BYTES;
		trailer = {tail_bytes[7:0], tail_bytes[15:8], tail_bytes[23:16], tail_bytes[31:24]};
		if (rec_bytes > size_limit) begin
			verdict.status = ST_TOO_LARGE;
		end else if (rec_bytes < HDR_TRL_BYTES || !magic_seen_ok) begin
			verdict.status = ST_BAD_MAGIC;
		end else if (len_gather != rec_bytes - HDR_TRL_BYTES) begin
			verdict.status = ST_BAD_LEN;
		end else if (trailer != (crc_run ^ CRC_INIT)) begin
			verdict.status = ST_BAD_CRC;
		end else if (rev_gather == '0) begin
			verdict.status = ST_ZERO_REV;
		end else begin
			verdict.status = ST_OK;
		end
		verdict.revision = rev_gather;
		verdict.payload_length = len_gather;
		expected_verdicts = {expected_verdicts, verdict};
		clear_record_state();
	endfunction

	// Builds one record and appends its bytes to the pending items. A nonzero
	// cut truncates the record to that many bytes when it is shorter than the
	// full record, which makes short records and broken trailers.
	function automatic void queue_record(rec_kind_t kind, int unsigned pay_len,
			logic [63:0] rev, int unsigned cut);
		logic [7:0] rec[$];
		logic [31:0] len_field;
		logic [31:0] crc;
		int unsigned pos;
		int unsigned n;
		int i;
		in_item_t next_item;
		len_field = pay_len;
		if (kind == REC_BAD_LEN) begin
			len_field ^= 32'd1 << $urandom_range(31);
		end
		if (kind == REC_JUNK) begin
			n = $urandom_range(60, 1);
			repeat (n) rec = {rec, 8'($urandom)};
		end else begin
			for (i = 0; i < 8; i++) rec = {rec, REC_MAGIC[63 - 8 * i -: 8]};
			for (i = 0; i < 8; i++) rec = {rec, rev[8 * i +: 8]};
			for (i = 0; i < 4; i++) rec = {rec, len_field[8 * i +: 8]};
			repeat (pay_len) rec = {rec, 8'($urandom)};
			if (kind == REC_BAD_MAGIC) begin
				pos = $urandom_range(MAGIC_BYTES - 1);
				rec[pos] ^= 8'(1 << $urandom_range(7));
			end
			crc = CRC_INIT;
			foreach (rec[j]) crc = crc32_step(crc, rec[j]);
			crc ^= CRC_INIT;
			if (kind == REC_BAD_CRC) begin
				crc ^= 32'd1 << $urandom_range(31);
			end
			for (i = 0; i < 4; i++) rec = {rec, crc[8 * i +: 8]};
			if (cut != 0) begin
				while (rec.size() > cut) void'(rec.pop_back());
			end
		end
		foreach (rec[j]) begin
			next_item.data_byte = rec[j];
			next_item.end_of_record = (j == rec.size() - 1);
			pending_bytes = {pending_bytes, next_item};
		end
	endfunction

	function automatic logic [63:0] pick_revision();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			return '0;
		end else if (r < 15) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	// A mix weighted toward well-formed records, so most of the stimulus
	// reaches the CRC and revision checks, with broken and junk records mixed in.
	function automatic void queue_random_record();
		int unsigned r;
		int unsigned pay_len;
		int unsigned cut;
		rec_kind_t kind;
		r = $urandom_range(99);
		if (r < 55) begin
			kind = REC_GOOD;
		end else if (r < 63) begin
			kind = REC_BAD_MAGIC;
		end else if (r < 71) begin
			kind = REC_BAD_LEN;
		end else if (r < 80) begin
			kind = REC_BAD_CRC;
		end else if (r < 90) begin
			kind = REC_GOOD;
		end else begin
			kind = REC_JUNK;
		end
		pay_len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(30, 7);
		cut = (r >= 80 && r < 90) ? $urandom_range(pay_len + 23, 1) : 0;
		queue_record(kind, pay_len, pick_revision(), cut);
	endfunction

	// The driver offers the next pending byte whenever the channel is free.
	// Valid is held, with the byte unchanged, until the block takes it.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_record_byte(in_item);
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The monitor checks every result taken against the oldest expected
	// verdict, and drives the receiver's ready with random stalls. A hold-off
	// request keeps ready low for a long stretch so the block backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					if (err_count < REPORT_LIMIT) begin
						$display("unexpected result: status %0d revision %h length %h",
							out_item.status, out_item.revision, out_item.payload_length);
					end
					err_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (out_item.status !== want.status
							|| out_item.revision !== want.revision
							|| out_item.payload_length !== want.payload_length) begin
						if (err_count < REPORT_LIMIT) begin
							$display("mismatch: expected status %0d revision %h length %h",
								want.status, want.revision, want.payload_length);
							$display("          got      status %0d revision %h length %h",
								out_item.status, out_item.revision, out_item.payload_length);
						end
						err_count++;
					end
				end
			end
			if (hold_len != 0) begin
				hold_len <= hold_len - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Waits until every pending byte is taken and every verdict has come out,
	// then lets the pipeline run dry before anything else changes. The
	// queues are looked at on the falling edge, once the driver and the
	// monitor have finished with the rising one.
	task automatic settle();
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The limit is only written while the block is idle, so the predictor's
	// copy can follow at once.
	task automatic write_payload_limit(logic [MAX_PL_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		payload_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		payload_limit = MAX_PL_RESET;
		clear_record_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records at the reset limit: one of each verdict but too large, the
		// revision at both extremes, and short records of one byte, of part
		// of the revision, and of one byte less than the smallest record.
		queue_record(REC_GOOD, 0, {$urandom, $urandom} | 64'd1, 0);
		queue_record(REC_GOOD, 3, '1, 0);
		queue_record(REC_GOOD, 2, '0, 0);
		queue_record(REC_BAD_MAGIC, 1, 64'h0123_4567_89AB_CDEF, 0);
		queue_record(REC_BAD_LEN, 2, 64'd7, 0);
		queue_record(REC_BAD_CRC, 0, 64'd9, 0);
		queue_record(REC_GOOD, 0, 64'h1111_2222_3333_4444, 1);
		queue_record(REC_GOOD, 0, 64'h5555_6666_7777_8888, 12);
		queue_record(REC_GOOD, 0, 64'h9999_AAAA_BBBB_CCCC, 23);
		settle();

		// With no payload allowed an empty record is exactly at the limit,
		// and one more byte is too large whatever else is wrong with it.
		write_payload_limit('0);
		queue_record(REC_GOOD, 0, 64'd1, 0);
		queue_record(REC_GOOD, 1, 64'd1, 0);
		queue_record(REC_BAD_MAGIC, 1, 64'd0, 0);
		settle();

		write_payload_limit(PL_LIMIT_TOP);
		queue_record(REC_GOOD, 4, 64'd3, 0);
		settle();

		// Random records under three idle patterns: a busy receiver, a slow
		// sender, then neither idling. Small limits make the too-large check
		// fire on ordinary records.
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 68 : 0;
			recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 13 : 0;
			write_payload_limit((mode == 2) ? PL_LIMIT_TOP : 25'($urandom_range(30)));
			repeat (2) queue_random_record();
			settle();
		end

		// Back-pressure: the receiver holds off for a long stretch while the
		// sender keeps offering tiny records, each of which yields a result,
		// so the output register fills and the input stalls.
		write_payload_limit(25'd5);
		@(posedge clk);
		hold_len <= PRESSURE_HOLD;
		repeat (20) queue_record(REC_GOOD, 0, 64'd1, $urandom_range(3, 1));
		repeat (2) queue_record(REC_GOOD, $urandom_range(5), pick_revision(), 0);
		settle();

		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/crcv_pkg.sv
rtl/core/crcv_crc_byte.sv
rtl/core/crcv_record.sv
rtl/core/crc_checked_record_validator.sv
rtl/core/crcv_checker.sv
verif/tb_crc_checked_record_validator.sv
